// File: rtl/core/assert_macros.svh
// assertion macros shared by the core rtl
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// condition must hold on every rising clock edge out of reset
`define SJF_ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("assertion failed");

// consequent must hold in the cycle of the antecedent
`define SJF_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

`else

`define SJF_ASSERT_ALWAYS(lbl, clk, rstn, expr)

`define SJF_ASSERT_IMPL(lbl, clk, rstn, ante, cons)

`endif

`endif

// File: rtl/core/sjf_pkg.sv
// shared types and constants of the shortest-job-first scheduler core
// no dependencies
package sjf_pkg;

    localparam int          QUEUE_DEPTH_DEF = 16;
    localparam logic [15:0] STEP_RESET      = 16'd20;

    localparam logic CMD_INSERT   = 1'b0;
    localparam logic CMD_DISPATCH = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_INS_WR,
        S_DSP_RD,
        S_DSP_DATA,
        S_DSP_TURN,
        S_EMIT
    } t_state;

    // one queue entry as stored in the ram
    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  prio;
        logic [15:0] burst;
        logic [31:0] arrival;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

// File: rtl/core/shortest_job_first_scheduler_core.sv
// shortest-job-first scheduler core: sorted circular queue held in one ram
// one command at a time; a dispatch reads the head in S_DSP_RD, pops it in S_DSP_DATA,
//   forms the turnaround in S_DSP_TURN and holds in S_EMIT through output stalls; an
//   error word goes to S_EMIT; inserts loop S_INS_RD/S_INS_CMP, then write in S_INS_WR
// reset: synchronous active-low; queue empty, both clocks zero, step 20,
//   ram contents left as they are (only live entries are ever read)
module shortest_job_first_scheduler_core #(
    parameter int QUEUE_DEPTH = sjf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_wdata,
    // command channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_command,
    input  logic [15:0]        i_job_id,
    input  logic [7:0]         i_priority_req,
    input  logic [15:0]        i_burst_time,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_status,
    output logic [15:0]        o_job_id_res,
    output logic [7:0]         o_priority_res,
    output logic [15:0]        o_burst_time_res,
    output logic signed [31:0] o_turnaround_time
);

    `include "assert_macros.svh"

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [SUM_W-1:0] SUM_DEPTH = SUM_W'(QUEUE_DEPTH);

    // circular pointer steps, depth need not be a power of two
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_LAST : p - 1'b1;
    endfunction

    // control state
    sjf_pkg::t_state    r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [PTR_W-1:0]   r_head, n_head;
    logic [31:0]        r_arrival, n_arrival;
    logic [31:0]        r_completion, n_completion;
    logic [15:0]        r_step, n_step;
    logic               r_out_valid, n_out_valid;

    // insert walk: new entry, slot being filled, slot being read, entries left
    sjf_pkg::t_entry    r_new, n_new;
    logic [PTR_W-1:0]   r_cur, n_cur;
    logic [PTR_W-1:0]   r_rd, n_rd;
    logic [CNT_W-1:0]   r_left, n_left;

    // pending result word
    sjf_pkg::t_status   r_pend_st, n_pend_st;
    logic [15:0]        r_pend_id, n_pend_id;
    logic [7:0]         r_pend_pr, n_pend_pr;
    logic [15:0]        r_pend_bu, n_pend_bu;
    logic [31:0]        r_pend_ta, n_pend_ta;

    // output register
    logic [1:0]         r_out_st, n_out_st;
    logic [15:0]        r_out_id, n_out_id;
    logic [7:0]         r_out_pr, n_out_pr;
    logic [15:0]        r_out_bu, n_out_bu;
    logic [31:0]        r_out_ta, n_out_ta;

    // ram port
    logic                        ram_we;
    logic [PTR_W-1:0]            ram_waddr;
    sjf_pkg::t_entry             ram_wdata;
    logic [PTR_W-1:0]            ram_raddr;
    logic [sjf_pkg::ENTRY_W-1:0] ram_rdata_raw;
    sjf_pkg::t_entry             ram_rdata;

    logic [SUM_W-1:0]   tail_sum;
    logic [PTR_W-1:0]   tail;
    logic               in_accept;
    logic               out_free;

    sjf_ram #(
        .WIDTH (sjf_pkg::ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata_raw)
    );

    assign ram_rdata = sjf_pkg::t_entry'(ram_rdata_raw);

    // first free slot behind the live entries
    assign tail_sum = SUM_W'(r_head) + SUM_W'(r_count);
    assign tail     = (tail_sum >= SUM_DEPTH) ? PTR_W'(tail_sum - SUM_DEPTH)
                                              : PTR_W'(tail_sum);

    // commands are taken only between operations; the output register
    // still lets a new command start while an earlier word waits
    assign o_in_ready = (r_state == sjf_pkg::S_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_head       = r_head;
        n_arrival    = r_arrival;
        n_completion = r_completion;
        n_step       = r_step;
        n_new        = r_new;
        n_cur        = r_cur;
        n_rd         = r_rd;
        n_left       = r_left;
        n_pend_st    = r_pend_st;
        n_pend_id    = r_pend_id;
        n_pend_pr    = r_pend_pr;
        n_pend_bu    = r_pend_bu;
        n_pend_ta    = r_pend_ta;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_st     = r_out_st;
        n_out_id     = r_out_id;
        n_out_pr     = r_out_pr;
        n_out_bu     = r_out_bu;
        n_out_ta     = r_out_ta;
        ram_we       = 1'b0;
        ram_waddr    = r_cur;
        ram_wdata    = r_new;
        ram_raddr    = r_rd;

        if (i_cfg_we) begin
            n_step = i_cfg_wdata;
        end

        case (r_state)
            sjf_pkg::S_IDLE: begin
                if (in_accept) begin
                    if (i_command == sjf_pkg::CMD_INSERT) begin
                        if (r_count == CNT_FULL) begin
                            n_pend_st = sjf_pkg::ST_FULL;
                            n_pend_id = '0;
                            n_pend_pr = '0;
                            n_pend_bu = '0;
                            n_pend_ta = '0;
                            n_state   = sjf_pkg::S_EMIT;
                        end else begin
                            n_new.id      = i_job_id;
                            n_new.prio    = i_priority_req;
                            n_new.burst   = i_burst_time;
                            n_new.arrival = r_arrival;
                            n_cur         = tail;
                            n_rd          = ptr_dec(tail);
                            n_left        = r_count;
                            n_state       = (r_count == '0) ? sjf_pkg::S_INS_WR
                                                            : sjf_pkg::S_INS_RD;
                        end
                    end else begin
                        // arrival clock moves even when the queue is empty
                        n_arrival = r_arrival + 32'(r_step);
                        if (r_count == '0) begin
                            n_pend_st = sjf_pkg::ST_EMPTY;
                            n_pend_id = '0;
                            n_pend_pr = '0;
                            n_pend_bu = '0;
                            n_pend_ta = '0;
                            n_state   = sjf_pkg::S_EMIT;
                        end else begin
                            n_state = sjf_pkg::S_DSP_RD;
                        end
                    end
                end
            end

            sjf_pkg::S_INS_RD: begin
                ram_raddr = r_rd;
                n_state   = sjf_pkg::S_INS_CMP;
            end

            sjf_pkg::S_INS_CMP: begin
                // strictly longer bursts move back one slot, equal ones stay ahead
                if (ram_rdata.burst > r_new.burst) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_cur;
                    ram_wdata = ram_rdata;
                    n_cur     = r_rd;
                    n_rd      = ptr_dec(r_rd);
                    n_left    = r_left - 1'b1;
                    n_state   = (r_left == CNT_W'(1)) ? sjf_pkg::S_INS_WR
                                                      : sjf_pkg::S_INS_RD;
                end else begin
                    n_state = sjf_pkg::S_INS_WR;
                end
            end

            sjf_pkg::S_INS_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_cur;
                ram_wdata = r_new;
                n_count   = r_count + 1'b1;
                n_state   = sjf_pkg::S_IDLE;
            end

            sjf_pkg::S_DSP_RD: begin
                ram_raddr = r_head;
                n_state   = sjf_pkg::S_DSP_DATA;
            end

            sjf_pkg::S_DSP_DATA: begin
                // head word is out of the ram; pop it and bump the completion clock
                n_pend_st    = sjf_pkg::ST_OK;
                n_pend_id    = ram_rdata.id;
                n_pend_pr    = ram_rdata.prio;
                n_pend_bu    = ram_rdata.burst;
                n_pend_ta    = ram_rdata.arrival;
                n_completion = r_completion + 32'(ram_rdata.burst);
                n_head       = ptr_inc(r_head);
                n_count      = r_count - 1'b1;
                n_state      = sjf_pkg::S_DSP_TURN;
            end

            sjf_pkg::S_DSP_TURN: begin
                // pending turnaround held the arrival stamp until now
                n_pend_ta = r_completion - r_pend_ta;
                n_state   = sjf_pkg::S_EMIT;
            end

            sjf_pkg::S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_st    = r_pend_st;
                    n_out_id    = r_pend_id;
                    n_out_pr    = r_pend_pr;
                    n_out_bu    = r_pend_bu;
                    n_out_ta    = r_pend_ta;
                    n_state     = sjf_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = sjf_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= sjf_pkg::S_IDLE;
            r_count      <= '0;
            r_head       <= '0;
            r_arrival    <= '0;
            r_completion <= '0;
            r_step       <= sjf_pkg::STEP_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_head       <= n_head;
            r_arrival    <= n_arrival;
            r_completion <= n_completion;
            r_step       <= n_step;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_new     <= n_new;
        r_cur     <= n_cur;
        r_rd      <= n_rd;
        r_left    <= n_left;
        r_pend_st <= n_pend_st;
        r_pend_id <= n_pend_id;
        r_pend_pr <= n_pend_pr;
        r_pend_bu <= n_pend_bu;
        r_pend_ta <= n_pend_ta;
        r_out_st  <= n_out_st;
        r_out_id  <= n_out_id;
        r_out_pr  <= n_out_pr;
        r_out_bu  <= n_out_bu;
        r_out_ta  <= n_out_ta;
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out_st;
    assign o_job_id_res      = r_out_id;
    assign o_priority_res    = r_out_pr;
    assign o_burst_time_res  = r_out_bu;
    assign o_turnaround_time = signed'(r_out_ta);

    // fill level never passes the ram depth
    `SJF_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_FULL)
    // a pop only reads the ram when a live entry is there
    `SJF_ASSERT_IMPL(a_pop_nonempty, i_clk, i_rst_n, r_state == sjf_pkg::S_DSP_DATA, r_count != '0)
    // the insert walk never compares past the head of the queue
    `SJF_ASSERT_IMPL(a_walk_bound, i_clk, i_rst_n, r_state == sjf_pkg::S_INS_CMP, r_left != '0)

endmodule

// File: rtl/core/sjf_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module sjf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
